// ----- hw/rtl/fic_pkg.sv -----
// ----------------------------------------------------------------------------
// fic_pkg
// Shared types and constants for the float/integer converter.
// ----------------------------------------------------------------------------
package fic_pkg;

	localparam int unsigned INT_W  = 32;
	localparam int unsigned MANT_W = 23;
	localparam int unsigned EXP_W  = 8;

	localparam logic FUNC_F2I = 1'b0;
	localparam logic FUNC_I2F = 1'b1;

	localparam logic REG_POS_SENTINEL = 1'b0;
	localparam logic REG_NEG_SENTINEL = 1'b1;

	localparam logic [EXP_W-1:0] EXP_ONE  = 8'd127;
	localparam logic [EXP_W-1:0] EXP_MANT = 8'd150;
	localparam logic [EXP_W-1:0] EXP_SAT  = 8'd158;

	localparam logic [INT_W-1:0] FLOAT_POS_INF = 32'h7F80_0000;
	localparam logic [INT_W-1:0] FLOAT_NEG_INF = 32'hFF80_0000;

	localparam logic [INT_W-1:0] POS_SENTINEL_RST = 32'h7FFF_FFFF;
	localparam logic [INT_W-1:0] NEG_SENTINEL_RST = 32'h8000_0000;

	typedef struct packed {
		logic [INT_W-1:0] pos_sentinel;
		logic [INT_W-1:0] neg_sentinel;
	} cfg_t;

endpackage

// ----- hw/rtl/fic_regs.sv -----
// ----------------------------------------------------------------------------
// fic_regs
// APB register file holding the positive and negative sentinel values.
// ----------------------------------------------------------------------------
module fic_regs
	import fic_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [INT_W-1:0]  pwdata,
	output logic [INT_W-1:0]  prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic             wr_en;
	logic             reg_sel;
	logic [INT_W-1:0] pos_q;
	logic [INT_W-1:0] neg_q;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_SENTINEL_RST;
			neg_q <= NEG_SENTINEL_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_POS_SENTINEL: pos_q <= pwdata;
				REG_NEG_SENTINEL: neg_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_POS_SENTINEL: prdata = pos_q;
			REG_NEG_SENTINEL: prdata = neg_q;
			default:          prdata = '0;
		endcase
	end

	assign cfg.pos_sentinel = pos_q;
	assign cfg.neg_sentinel = neg_q;

endmodule

// ----- hw/rtl/fic_datapath.sv -----
// ----------------------------------------------------------------------------
// fic_datapath
// Three-stage conversion pipeline: classify, shift or leading-one search,
// then normalize, negate and select.
// ----------------------------------------------------------------------------
module fic_datapath
	import fic_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              func,
	input  logic [INT_W-1:0]  operand_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [INT_W-1:0]  result_out
);

	typedef struct packed {
		logic             func;
		logic             sign;
		logic             f_zero;
		logic             f_sat;
		logic             f_right;
		logic [4:0]       shamt;
		logic             i_zero;
		logic             i_pinf;
		logic             i_ninf;
		logic [INT_W-1:0] data;
	} stage_t;

	typedef struct packed {
		logic             func;
		logic             sign;
		logic             f_zero;
		logic             f_sat;
		logic             i_zero;
		logic             i_pinf;
		logic             i_ninf;
		logic [4:0]       top;
		logic [INT_W-1:0] data;
	} mid_t;

	logic             valid_s1, valid_s2, valid_s3;
	logic             en_s1, en_s2, en_s3;
	stage_t           nx_s1, data_s1;
	mid_t             nx_s2, data_s2;
	logic [INT_W-1:0] nx_s3, result_s3;
	logic [EXP_W-1:0] expf;
	logic [15:0]      lod16;
	logic [7:0]       lod8;
	logic [3:0]       lod4;
	logic [1:0]       lod2;
	logic [INT_W-1:0] norm;

	assign en_s3    = !valid_s3 || out_ready;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
		end
	end

	// classify and take magnitude
	always_comb begin
		expf          = operand_in[30:23];
		nx_s1.func    = func;
		nx_s1.sign    = operand_in[31];
		nx_s1.f_zero  = expf < EXP_ONE;
		nx_s1.f_sat   = expf >= EXP_SAT;
		nx_s1.f_right = expf <= EXP_MANT;
		nx_s1.shamt   = nx_s1.f_right ? 5'(EXP_MANT - expf) : 5'(expf - EXP_MANT);
		nx_s1.i_zero  = operand_in == '0;
		nx_s1.i_pinf  = operand_in == cfg.pos_sentinel;
		nx_s1.i_ninf  = operand_in == cfg.neg_sentinel;
		if (func == FUNC_I2F) begin
			nx_s1.data = operand_in[31] ? (INT_W'(0) - operand_in) : operand_in;
		end else begin
			nx_s1.data = {{(INT_W-MANT_W-1){1'b0}}, 1'b1, operand_in[MANT_W-1:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) data_s1 <= nx_s1;
	end

	// align mantissa, find leading one
	always_comb begin
		nx_s2.func   = data_s1.func;
		nx_s2.sign   = data_s1.sign;
		nx_s2.f_zero = data_s1.f_zero;
		nx_s2.f_sat  = data_s1.f_sat;
		nx_s2.i_zero = data_s1.i_zero;
		nx_s2.i_pinf = data_s1.i_pinf;
		nx_s2.i_ninf = data_s1.i_ninf;

		nx_s2.top[4] = data_s1.data[31:16] != '0;
		lod16        = nx_s2.top[4] ? data_s1.data[31:16] : data_s1.data[15:0];
		nx_s2.top[3] = lod16[15:8] != '0;
		lod8         = nx_s2.top[3] ? lod16[15:8] : lod16[7:0];
		nx_s2.top[2] = lod8[7:4] != '0;
		lod4         = nx_s2.top[2] ? lod8[7:4] : lod8[3:0];
		nx_s2.top[1] = lod4[3:2] != '0;
		lod2         = nx_s2.top[1] ? lod4[3:2] : lod4[1:0];
		nx_s2.top[0] = lod2[1];

		if (data_s1.func == FUNC_I2F) begin
			nx_s2.data = data_s1.data;
		end else if (data_s1.f_right) begin
			nx_s2.data = data_s1.data >> data_s1.shamt;
		end else begin
			nx_s2.data = data_s1.data << data_s1.shamt;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) data_s2 <= nx_s2;
	end

	// normalize, negate, select specials
	always_comb begin
		norm = data_s2.data << (5'd31 - data_s2.top);
		if (data_s2.func == FUNC_I2F) begin
			priority if (data_s2.i_zero) begin
				nx_s3 = '0;
			end else if (data_s2.i_pinf) begin
				nx_s3 = FLOAT_POS_INF;
			end else if (data_s2.i_ninf) begin
				nx_s3 = FLOAT_NEG_INF;
			end else begin
				nx_s3 = {data_s2.sign, EXP_W'(EXP_ONE + {3'b000, data_s2.top}),
					norm[INT_W-2:INT_W-1-MANT_W]};
			end
		end else begin
			priority if (data_s2.f_zero) begin
				nx_s3 = '0;
			end else if (data_s2.f_sat) begin
				nx_s3 = data_s2.sign ? cfg.neg_sentinel : cfg.pos_sentinel;
			end else if (data_s2.sign) begin
				nx_s3 = INT_W'(0) - data_s2.data;
			end else begin
				nx_s3 = data_s2.data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && valid_s2) result_s3 <= nx_s3;
	end

	assign out_valid  = valid_s3;
	assign result_out = result_s3;

endmodule

// ----- hw/rtl/float_int_converter.sv -----
// ----------------------------------------------------------------------------
// float_int_converter
// IEEE 754 single <-> 32-bit signed integer converter, truncating, with
// programmable sentinels for signed infinity.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | carries
//  ---------+-------------------------------------------+------------------
//  in       | in_valid, in_ready, func, operand_in      | request
//  out      | out_valid, out_ready, result_out          | result
//  apb      | psel, penable, pwrite, paddr, pwdata,     | sentinel regs
//           | prdata, pready                            |
//
//  Three pipeline registers lie between request and result: classify,
//  align or leading-one search, normalize and select. One request per
//  cycle is taken unless out_ready stalls a full pipeline.
//  Reset clears the valid bits and loads the sentinel defaults.
//  A stall on out_ready holds each full stage; empty stages still fill.
// ----------------------------------------------------------------------------
module float_int_converter
	import fic_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [INT_W-1:0]  pwdata,
	output logic [INT_W-1:0]  prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              func,
	input  logic [INT_W-1:0]  operand_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [INT_W-1:0]  result_out
);

	cfg_t cfg;

	fic_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fic_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.operand_in (operand_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result_out (result_out)
	);

endmodule
